/* design/lps_pkg.sv */
// Shared types and constants for the line pixel stepper.
// Used by the front, back and top-level modules; depends on nothing.
package lps_pkg;

  // Color field width, fixed by the pixel format.
  localparam int unsigned COLOR_W = 24;

  // Operation codes carried on in_tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Classified command control bits passed from the front to the back.
  typedef struct packed {
    logic is_start;
    logic dir_x_neg;
    logic dir_y_neg;
  } lps_ctl_t;

  localparam int unsigned CTL_W = $bits(lps_ctl_t);

endpackage

/* design/lps_front.sv */
// Front end of the line pixel stepper: accepts input transactions, classifies
// them and precomputes the line setup terms. Depends on lps_pkg.
module lps_front #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [COORD_WIDTH-1:0]       x_start,
  input  logic signed [COORD_WIDTH-1:0]       y_start,
  input  logic signed [COORD_WIDTH-1:0]       x_end,
  input  logic signed [COORD_WIDTH-1:0]       y_end,
  input  logic [lps_pkg::COLOR_W-1:0]         color_in,
  input  logic                                q_ready,
  output logic                                q_push,
  output lps_pkg::lps_ctl_t                   ctl,
  output logic [COORD_WIDTH-1:0]              span_x,
  output logic [COORD_WIDTH-1:0]              span_y,
  output logic signed [COORD_WIDTH+1:0]       err_init
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned EW = COORD_WIDTH + 2;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        abs_dx;
  logic [DW-1:0]        abs_dy;

  // Handshake passes straight through to the queue.
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Deltas, their magnitudes and the initial error term.
  always_comb begin
    dx       = DW'(x_end) - DW'(x_start);
    dy       = DW'(y_end) - DW'(y_start);
    abs_dx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    abs_dy   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    span_x   = abs_dx[COORD_WIDTH-1:0];
    span_y   = abs_dy[COORD_WIDTH-1:0];
    err_init = $signed(EW'({1'b0, abs_dx})) - $signed(EW'({1'b0, abs_dy}));
  end

  // Classification and step directions.
  always_comb begin
    ctl.is_start  = (op == lps_pkg::OP_START);
    ctl.dir_x_neg = !(x_start < x_end);
    ctl.dir_y_neg = !(y_start < y_end);
  end

endmodule

/* design/lps_queue.sv */
// Two-entry command queue between the front and back of the stepper.
// Generic payload width; depends on nothing.
module lps_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/lps_back.sv */
// Back end of the line pixel stepper: holds the line state, runs one Bresenham
// step per step command while busy and drives the output register. Depends on lps_pkg.
module lps_back #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  lps_pkg::lps_ctl_t             ctl,
  input  logic signed [COORD_WIDTH-1:0] x_start,
  input  logic signed [COORD_WIDTH-1:0] y_start,
  input  logic signed [COORD_WIDTH-1:0] x_end,
  input  logic signed [COORD_WIDTH-1:0] y_end,
  input  logic [lps_pkg::COLOR_W-1:0]   color_in,
  input  logic [COORD_WIDTH-1:0]        span_x,
  input  logic [COORD_WIDTH-1:0]        span_y,
  input  logic signed [COORD_WIDTH+1:0] err_init,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] pixel_x,
  output logic signed [COORD_WIDTH-1:0] pixel_y,
  output logic [lps_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = COORD_WIDTH + 2;
  localparam int unsigned AW = EW + 1;

  // Line state.
  logic signed [CW-1:0]         cur_x_r, cur_x_nxt;
  logic signed [CW-1:0]         cur_y_r, cur_y_nxt;
  logic signed [CW-1:0]         tgt_x_r, tgt_x_nxt;
  logic signed [CW-1:0]         tgt_y_r, tgt_y_nxt;
  logic [CW-1:0]                span_x_r, span_x_nxt;
  logic [CW-1:0]                span_y_r, span_y_nxt;
  logic                         dir_x_neg_r, dir_x_neg_nxt;
  logic                         dir_y_neg_r, dir_y_neg_nxt;
  logic signed [EW-1:0]         err_r, err_nxt;
  logic [lps_pkg::COLOR_W-1:0]  color_r, color_nxt;
  logic                         busy_r, busy_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic signed [CW-1:0]         out_x_r;
  logic signed [CW-1:0]         out_y_r;
  logic [lps_pkg::COLOR_W-1:0]  out_color_r;
  logic                         out_last_r;

  // Step datapath.
  logic signed [AW-1:0]         e2;
  logic signed [AW-1:0]         sx_ext;
  logic signed [AW-1:0]         sy_ext;
  logic signed [AW-1:0]         err_acc;
  logic                         step_x;
  logic                         step_y;
  logic                         emit;
  logic                         at_end;

  // A command is taken whenever the output register is free or draining.
  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);
  assign emit    = cmd_pop && (ctl.is_start || busy_r);

  // One Bresenham step from the current state.
  always_comb begin
    e2      = $signed({err_r, 1'b0});
    sx_ext  = $signed(AW'(span_x_r));
    sy_ext  = $signed(AW'(span_y_r));
    step_x  = (e2 > -sy_ext);
    step_y  = (e2 < sx_ext);
    err_acc = AW'(err_r);
    if (step_x) begin
      err_acc = err_acc - sy_ext;
    end
    if (step_y) begin
      err_acc = err_acc + sx_ext;
    end
  end

  // Next line state: load on start, advance on a step while busy.
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    span_x_nxt    = span_x_r;
    span_y_nxt    = span_y_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    if (ctl.is_start) begin
      cur_x_nxt     = x_start;
      cur_y_nxt     = y_start;
      tgt_x_nxt     = x_end;
      tgt_y_nxt     = y_end;
      span_x_nxt    = span_x;
      span_y_nxt    = span_y;
      dir_x_neg_nxt = ctl.dir_x_neg;
      dir_y_neg_nxt = ctl.dir_y_neg;
      err_nxt       = err_init;
      color_nxt     = color_in;
    end else begin
      if (step_x) begin
        cur_x_nxt = dir_x_neg_r ? CW'(cur_x_r - 1'b1) : CW'(cur_x_r + 1'b1);
      end
      if (step_y) begin
        cur_y_nxt = dir_y_neg_r ? CW'(cur_y_r - 1'b1) : CW'(cur_y_r + 1'b1);
      end
      err_nxt = err_acc[EW-1:0];
    end
    at_end   = (cur_x_nxt == tgt_x_nxt) && (cur_y_nxt == tgt_y_nxt);
    busy_nxt = emit ? !at_end : busy_r;
  end

  // Output valid holds until the transaction completes.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Line state and result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      span_x_r    <= span_x_nxt;
      span_y_r    <= span_y_nxt;
      dir_x_neg_r <= dir_x_neg_nxt;
      dir_y_neg_r <= dir_y_neg_nxt;
      err_r       <= err_nxt;
      color_r     <= color_nxt;
      out_x_r     <= cur_x_nxt;
      out_y_r     <= cur_y_nxt;
      out_color_r <= color_nxt;
      out_last_r  <= at_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign pixel_x     = out_x_r;
  assign pixel_y     = out_y_r;
  assign pixel_color = out_color_r;
  assign last        = out_last_r;

endmodule

/* design/line_pixel_stepper.sv */
// Line pixel stepper: Bresenham line engine emitting one pixel per start and per step taken while busy.
// Each input transaction is registered in the command queue; the back end then registers its result.
// Throughput: one input transaction per cycle while out_tready keeps up, set by the step
// adder and compare in the back end and the two-entry command queue; back-pressure stalls it.
// Reset (rst_n low, synchronous): empties the queue, drops any pending result
// and leaves the engine idle, so steps give no result until the next start.
module line_pixel_stepper #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // in_tdata, low bit up: x_start, y_start, x_end, y_end, color_in, zero pad
  input  logic [((4*COORD_WIDTH+lps_pkg::COLOR_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: operation
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_tdata, low bit up: pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_WIDTH+lps_pkg::COLOR_W+7)/8)*8-1:0] out_tdata,
  // out_tlast: last
  output logic                 out_tlast
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned EW     = COORD_WIDTH + 2;
  localparam int unsigned CLR_W  = lps_pkg::COLOR_W;
  localparam int unsigned OUT_DW = ((2*CW+CLR_W+7)/8)*8;
  localparam int unsigned Q_W    = lps_pkg::CTL_W + 6*CW + EW + CLR_W;

  // Input field unpacking.
  logic signed [CW-1:0] x_start;
  logic signed [CW-1:0] y_start;
  logic signed [CW-1:0] x_end;
  logic signed [CW-1:0] y_end;
  logic [CLR_W-1:0]     color_in;

  assign x_start  = in_tdata[CW-1:0];
  assign y_start  = in_tdata[2*CW-1:CW];
  assign x_end    = in_tdata[3*CW-1:2*CW];
  assign y_end    = in_tdata[4*CW-1:3*CW];
  assign color_in = in_tdata[4*CW+CLR_W-1:4*CW];

  // Front end outputs.
  logic                 q_ready;
  logic                 q_push;
  lps_pkg::lps_ctl_t    f_ctl;
  logic [CW-1:0]        f_span_x;
  logic [CW-1:0]        f_span_y;
  logic signed [EW-1:0] f_err;

  lps_front #(
    .COORD_WIDTH (CW)
  ) u_front (
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .color_in (color_in),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .ctl      (f_ctl),
    .span_x   (f_span_x),
    .span_y   (f_span_y),
    .err_init (f_err)
  );

  // Command queue.
  logic [Q_W-1:0] q_in;
  logic [Q_W-1:0] q_out;
  logic           q_valid;
  logic           q_pop;

  assign q_in = {f_ctl, f_err, f_span_y, f_span_x, color_in, y_end, x_end, y_start, x_start};

  lps_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  // Queue head unpacking.
  lps_pkg::lps_ctl_t    b_ctl;
  logic signed [EW-1:0] b_err;
  logic [CW-1:0]        b_span_x;
  logic [CW-1:0]        b_span_y;
  logic [CLR_W-1:0]     b_color;
  logic signed [CW-1:0] b_x0;
  logic signed [CW-1:0] b_y0;
  logic signed [CW-1:0] b_x1;
  logic signed [CW-1:0] b_y1;

  assign {b_ctl, b_err, b_span_y, b_span_x, b_color, b_y1, b_x1, b_y0, b_x0} = q_out;

  // Back end results.
  logic signed [CW-1:0] pixel_x;
  logic signed [CW-1:0] pixel_y;
  logic [CLR_W-1:0]     pixel_color;

  lps_back #(
    .COORD_WIDTH (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .ctl         (b_ctl),
    .x_start     (b_x0),
    .y_start     (b_y0),
    .x_end       (b_x1),
    .y_end       (b_y1),
    .color_in    (b_color),
    .span_x      (b_span_x),
    .span_y      (b_span_y),
    .err_init    (b_err),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (out_tlast)
  );

  assign out_tdata = OUT_DW'({pixel_color, pixel_y, pixel_x});

endmodule

/* verif/lps_pixel_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the line pixel stepper: watches both stream channels, walks each line in step
// with the block and compares every pixel it sends. Depends on lps_pkg only.
module lps_pixel_checker #(
  parameter int unsigned COORD_W = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // in_tdata, low bit up: x_start, y_start, x_end, y_end, color_in, zero pad
  input  logic [((4*COORD_W+lps_pkg::COLOR_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: operation
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // out_tdata, low bit up: pixel_x, pixel_y, pixel_color, zero pad
  input  logic [((2*COORD_W+lps_pkg::COLOR_W+7)/8)*8-1:0] out_tdata,
  // out_tlast: last
  input  logic                 out_tlast,
  output int                   fail_count,
  output int                   pending_pixels
);

  localparam int unsigned COLOR_W = lps_pkg::COLOR_W;
  localparam int unsigned IN_W    = ((4*COORD_W+COLOR_W+7)/8)*8;
  localparam int unsigned ERR_W   = COORD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } pixel_t;

  // Pixels the block still owes, oldest first.
  pixel_t pixel_queue[$];
  pixel_t got_px;
  pixel_t want_px;

  // Line walker state, kept in step with the block.
  logic signed [COORD_W-1:0] pos_x, pos_y, end_x, end_y;
  logic [COORD_W-1:0]        run_x, run_y;
  logic                      step_x_neg, step_y_neg;
  logic signed [ERR_W-1:0]   bres_err;
  logic [COLOR_W-1:0]        line_rgb;
  logic                      drawing;

  // Apply one accepted transaction to the walker and queue the pixel it yields, if any.
  function automatic void walk_line(input logic op, input logic [IN_W-1:0] word);
    int     dx, dy, e2, err_i;
    pixel_t px;
    if (op == lps_pkg::OP_START) begin
      pos_x      = word[COORD_W-1:0];
      pos_y      = word[2*COORD_W-1:COORD_W];
      end_x      = word[3*COORD_W-1:2*COORD_W];
      end_y      = word[4*COORD_W-1:3*COORD_W];
      line_rgb   = word[4*COORD_W +: COLOR_W];
      dx         = int'(end_x) - int'(pos_x);
      dy         = int'(end_y) - int'(pos_y);
      run_x      = COORD_W'((dx < 0) ? -dx : dx);
      run_y      = COORD_W'((dy < 0) ? -dy : dy);
      step_x_neg = !(pos_x < end_x);
      step_y_neg = !(pos_y < end_y);
      err_i      = int'(run_x) - int'(run_y);
      bres_err   = err_i[ERR_W-1:0];
    end else begin
      // A step with no line in progress is dropped silently.
      if (!drawing) return;
      err_i = int'(bres_err);
      e2    = 2 * err_i;
      if (e2 > -int'(run_y)) begin
        err_i = err_i - int'(run_y);
        pos_x = step_x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (e2 < int'(run_x)) begin
        err_i = err_i + int'(run_x);
        pos_y = step_y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
      end
      bres_err = err_i[ERR_W-1:0];
    end
    drawing  = !((pos_x == end_x) && (pos_y == end_y));
    px.x     = pos_x;
    px.y     = pos_y;
    px.color = line_rgb;
    px.last  = !drawing;
    pixel_queue.push_back(px);
  endfunction

  // Compare results first, then predict; a new transaction cannot answer in its own cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      pos_x      = '0;
      pos_y      = '0;
      end_x      = '0;
      end_y      = '0;
      run_x      = '0;
      run_y      = '0;
      step_x_neg = 1'b0;
      step_y_neg = 1'b0;
      bres_err   = '0;
      line_rgb   = '0;
      drawing    = 1'b0;
      fail_count = 0;
      pixel_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_px.x     = out_tdata[COORD_W-1:0];
        got_px.y     = out_tdata[2*COORD_W-1:COORD_W];
        got_px.color = out_tdata[2*COORD_W +: COLOR_W];
        got_px.last  = out_tlast;
        if (pixel_queue.size() == 0) begin
          $display("%0t: expected no pixel, got x=%0d y=%0d color=%06h last=%0b", $time,
                   got_px.x, got_px.y, got_px.color, got_px.last);
          fail_count++;
        end else begin
          want_px = pixel_queue.pop_front();
          if (got_px.x !== want_px.x) begin
            $display("%0t: pixel_x expected %0d, got %0d", $time, want_px.x, got_px.x);
            fail_count++;
          end
          if (got_px.y !== want_px.y) begin
            $display("%0t: pixel_y expected %0d, got %0d", $time, want_px.y, got_px.y);
            fail_count++;
          end
          if (got_px.color !== want_px.color) begin
            $display("%0t: pixel_color expected %06h, got %06h", $time,
                     want_px.color, got_px.color);
            fail_count++;
          end
          if (got_px.last !== want_px.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want_px.last, got_px.last);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        walk_line(in_tuser, in_tdata);
      end
    end
    pending_pixels = pixel_queue.size();
  end

endmodule

/* verif/tb_line_pixel_stepper.sv */
`timescale 1ns / 100ps
// Top of the line pixel stepper testbench: clock, reset, line stimulus and pixel back-pressure.
// Depends on lps_pkg, the line_pixel_stepper RTL and the lps_pixel_checker scoreboard.
module tb_line_pixel_stepper;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = lps_pkg::COLOR_W;
  localparam int unsigned IN_W    = ((4*COORD_W+COLOR_W+7)/8)*8;
  localparam int unsigned OUT_W   = ((2*COORD_W+COLOR_W+7)/8)*8;
  localparam int COORD_MIN        = -(1 <<< (COORD_W-1));
  localparam int COORD_MAX        = (1 <<< (COORD_W-1)) - 1;
  localparam int RANDOM_ITEMS     = 1400;
  localparam int LONG_HOLD        = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 20;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  int               fail_count;
  int               pending_pixels;

  // Stimulus bookkeeping shared by the sender, the receiver and the watchdog.
  int items_sent;
  bit tx_calm;
  bit rx_calm;
  bit hold_request;
  int idle_run;

  line_pixel_stepper #(
    .COORD_WIDTH(COORD_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  lps_pixel_checker #(
    .COORD_W(COORD_W)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_pixels(pending_pixels)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Offer one transaction after a random gap (none while tx_calm) and hold it until the block takes it.
  task automatic send_item(input logic op, input int xs, input int ys, input int xe,
                           input int ye, input logic [COLOR_W-1:0] rgb);
    int              gap;
    logic [IN_W-1:0] word;
    word = '0;
    word[COORD_W-1:0]           = xs[COORD_W-1:0];
    word[2*COORD_W-1:COORD_W]   = ys[COORD_W-1:0];
    word[3*COORD_W-1:2*COORD_W] = xe[COORD_W-1:0];
    word[4*COORD_W-1:3*COORD_W] = ye[COORD_W-1:0];
    word[4*COORD_W +: COLOR_W]  = rgb;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_line(input int xs, input int ys, input int xe, input int ye,
                            input logic [COLOR_W-1:0] rgb);
    send_item(lps_pkg::OP_START, xs, ys, xe, ye, rgb);
    items_sent++;
  endtask

  // Step with junk in the unused fields; steps expected to hit an idle engine are not counted.
  task automatic step_pixel(input bit counted);
    send_item(lps_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              COLOR_W'($urandom()));
    if (counted) items_sent++;
  endtask

  // One random line: mostly short and walked to the end, sometimes cut short,
  // sometimes spanning the whole plane with only a few steps before the next restart.
  task automatic random_segment();
    int xs, ys, xe, ye, reach, len, dx, dy, steps;
    xs = rand_coord();
    ys = rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      xe    = rand_coord();
      ye    = rand_coord();
      steps = $urandom_range(0, 5);
    end else begin
      reach = ($urandom_range(0, 9) == 0) ? 60 : 6;
      xe    = clamp_coord(xs + int'($urandom_range(0, 2*reach)) - reach);
      ye    = clamp_coord(ys + int'($urandom_range(0, 2*reach)) - reach);
      dx    = (xe > xs) ? xe - xs : xs - xe;
      dy    = (ye > ys) ? ye - ys : ys - ye;
      len   = (dx > dy) ? dx : dy;
      steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
    end
    start_line(xs, ys, xe, ye, COLOR_W'($urandom()));
    repeat (steps) step_pixel(1'b1);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) step_pixel(1'b0);
  endtask

  // Pixel receiver: random stalls per transaction, calm stretches, and one long hold-off.
  initial begin
    int gap;
    bit held;
    out_tready = 1'b0;
    rx_calm    = 1'b0;
    held       = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_request && !held) begin
        held       = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = rx_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
  end

  // Watchdog: too many cycles without any transaction on either channel ends the run.
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence: reset, directed lines, random lines, drain and verdict.
  initial begin
    bit hold_done;
    bit pause_done;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = lps_pkg::OP_STEP;
    tx_calm      = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Step on an idle engine right after reset gives nothing.
    step_pixel(1'b0);
    // Degenerate line: a single pixel marked last, then the engine stays idle.
    start_line(5, -7, 5, -7, 24'h000000);
    step_pixel(1'b0);
    // Full-plane diagonal from the lowest corner, restarted while still busy.
    start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'hFFFFFF);
    repeat (3) step_pixel(1'b1);
    start_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 24'h800001);
    repeat (2) step_pixel(1'b1);
    start_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'h5A5A5A);
    step_pixel(1'b1);
    // Short horizontal, vertical and steep lines walked to their end points.
    start_line(0, 0, 3, 0, 24'h123456);
    repeat (3) step_pixel(1'b1);
    start_line(10, 10, 10, 7, 24'hA5C3E1);
    repeat (3) step_pixel(1'b1);
    start_line(0, 0, -1, 3, 24'h0F0F0F);
    repeat (3) step_pixel(1'b1);

    // Random lines.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= 400) begin
        // Receiver holds off while the sender keeps pushing a long line at full rate.
        hold_done    = 1'b1;
        tx_calm      = 1'b1;
        hold_request = 1'b1;
        start_line(0, 0, 150, -61, 24'h3C5A7E);
        repeat (60) step_pixel(1'b1);
        tx_calm = 1'b0;
      end else if (!pause_done && items_sent >= 900) begin
        // Sender goes quiet until every pixel owed has come out.
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_pixels != 0) @(negedge clk);
      end else begin
        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        random_segment();
      end
    end
    in_tvalid <= 1'b0;

    // Drain the pixels still owed, then give late extras time to show up.
    @(negedge clk);
    while (pending_pixels != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
